[rtl/core/tpq_pkg.sv]
// shared types, codes and widths of the two-class priority queue
package tpq_pkg;

   localparam int ID_W            = 27;
   localparam int REQ_TYPE_W      = 2;
   localparam int STATUS_W        = 2;
   localparam int VIP_COUNT_W     = 5;
   localparam int TOTAL_COUNT_W   = 6;
   localparam int DEF_CLASS_DEPTH = 16;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY_REM = 2'd2;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic                  is_vip;
      logic [ID_W-1:0]       client_id;
   } req_type_type;

   typedef struct packed {
      logic                     head_valid;
      logic                     head_is_vip;
      logic [ID_W-1:0]          head_client_id;
      logic [VIP_COUNT_W-1:0]   vip_count;
      logic [TOTAL_COUNT_W-1:0] total_count;
      logic [STATUS_W-1:0]      status;
   } rsp_type;

   // per-ring update controls
   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } ring_ctrl_type;

endpackage

[rtl/core/two_class_priority_queue_core.sv]
// top level of the two-class priority queue: request decode, class rings, result register
//
//  channel   ports                     transfer when
//  request   start, busy, req_data     rising edge with start high and busy low
//  result    rsp_valid, rsp_data       every cycle rsp_valid is high, cannot be held off
//
// one request per cycle; its result is registered at the transfer edge
// busy is always low: each ring updates pointers and fill at the transfer edge
// the head of each ring is a registered read at the next read pointer
// reset clears pointers, fills and the result strobe; ring contents stay as they are
// no clearing pass is needed, so requests are taken right after reset
module two_class_priority_queue_core #(
   parameter int CLASS_DEPTH = tpq_pkg::DEF_CLASS_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tpq_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   output tpq_pkg::rsp_type      rsp_data
);

   localparam int FILL_W = $clog2(CLASS_DEPTH+1);
   localparam int SUM_W  = FILL_W + 1;
   localparam int VCNT_W = tpq_pkg::VIP_COUNT_W;
   localparam int TCNT_W = tpq_pkg::TOTAL_COUNT_W;
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(CLASS_DEPTH);

   logic accept;
   logic vip_nonempty, norm_nonempty;
   logic vip_full, norm_full;
   logic is_insert, is_remove, is_clear;

   tpq_pkg::ring_ctrl_type vip_ctrl, norm_ctrl;

   logic [FILL_W-1:0]             vip_fill, norm_fill;
   logic [tpq_pkg::ID_W-1:0]      vip_head, norm_head;
   logic [SUM_W-1:0]              total;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tpq_pkg::STATUS_W-1:0]  status_ff, status_in;

   // a new request is taken every cycle
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign vip_nonempty  = (vip_fill != '0);
   assign norm_nonempty = (norm_fill != '0);
   assign vip_full      = (vip_fill == FULL_FILL);
   assign norm_full     = (norm_fill == FULL_FILL);

   assign is_insert = accept && (req_data.req_type == tpq_pkg::REQ_INSERT);
   assign is_remove = accept && (req_data.req_type == tpq_pkg::REQ_REMOVE);
   assign is_clear  = accept && (req_data.req_type == tpq_pkg::REQ_CLEAR);

   // ring controls: vip entries leave first, a full class rejects the insert
   always_comb begin
      vip_ctrl.push   = is_insert && req_data.is_vip && !vip_full;
      vip_ctrl.pop    = is_remove && vip_nonempty;
      vip_ctrl.clear  = is_clear;
      norm_ctrl.push  = is_insert && !req_data.is_vip && !norm_full;
      norm_ctrl.pop   = is_remove && !vip_nonempty && norm_nonempty;
      norm_ctrl.clear = is_clear;
   end

   // status of the request being taken
   always_comb begin
      status_in = tpq_pkg::STAT_DONE;
      priority if (is_insert && (req_data.is_vip ? vip_full : norm_full)) begin
         status_in = tpq_pkg::STAT_FULL;
      end else if (is_remove && !vip_nonempty && !norm_nonempty) begin
         status_in = tpq_pkg::STAT_EMPTY_REM;
      end
   end

   assign rsp_valid_in = accept;

   tpq_ring #(
      .DEPTH (CLASS_DEPTH)
   ) u_vip_ring (
      .clock (clock),
      .reset (reset),
      .ctrl  (vip_ctrl),
      .wr_id (req_data.client_id),
      .fill  (vip_fill),
      .head  (vip_head)
   );

   tpq_ring #(
      .DEPTH (CLASS_DEPTH)
   ) u_norm_ring (
      .clock (clock),
      .reset (reset),
      .ctrl  (norm_ctrl),
      .wr_id (req_data.client_id),
      .fill  (norm_fill),
      .head  (norm_head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // status is payload only
   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   // result fields come straight from the updated ring state
   assign total = SUM_W'(vip_fill) + SUM_W'(norm_fill);

   always_comb begin
      rsp_data.head_valid  = vip_nonempty || norm_nonempty;
      rsp_data.head_is_vip = vip_nonempty;
      priority if (vip_nonempty) begin
         rsp_data.head_client_id = vip_head;
      end else if (norm_nonempty) begin
         rsp_data.head_client_id = norm_head;
      end else begin
         rsp_data.head_client_id = '0;
      end
      rsp_data.vip_count   = VCNT_W'(vip_fill);
      rsp_data.total_count = TCNT_W'(total);
      rsp_data.status      = status_ff;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/tpq_ring.sv]
// one class ring: storage, pointers, fill count and registered head entry
module tpq_ring #(
   parameter int DEPTH = tpq_pkg::DEF_CLASS_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tpq_pkg::ring_ctrl_type        ctrl,
   input  logic [tpq_pkg::ID_W-1:0]      wr_id,
   output logic [$clog2(DEPTH+1)-1:0]    fill,
   output logic [tpq_pkg::ID_W-1:0]      head
);

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH+1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH-1);

   logic [tpq_pkg::ID_W-1:0] mem [DEPTH];

   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [tpq_pkg::ID_W-1:0] head_ff;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      fill_in   = fill_ff;
      priority if (ctrl.clear) begin
         rd_ptr_in = '0;
         wr_ptr_in = '0;
         fill_in   = '0;
      end else if (ctrl.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
         fill_in   = fill_ff + FILL_W'(1);
      end else if (ctrl.pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
         fill_in   = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // write port
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[wr_ptr_ff] <= wr_id;
      end
   end

   // registered head read at the next read pointer, new entry bypassed into an empty ring
   always_ff @(posedge clock) begin
      if (ctrl.push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= wr_id;
      end else begin
         head_ff <= mem[rd_ptr_in];
      end
   end

   assign fill = fill_ff;
   assign head = head_ff;

endmodule

[sim/tb_two_class_priority_queue_core.sv]
// testbench of the two-class priority queue: directed table, then random checked requests
`timescale 1ns / 1ps

module tb_two_class_priority_queue_core;

   localparam int          CLASS_DEPTH = tpq_pkg::DEF_CLASS_DEPTH;
   localparam int          PTR_W       = $clog2(CLASS_DEPTH);
   localparam int unsigned MAX_ID      = 99999999;
   localparam int          RAND_ITEMS  = 1850;
   localparam int          CYCLE_LIMIT = 300000;
   localparam int          DRAIN_WAIT  = 4;
   localparam int          DIR_ROWS    = 22;

   // request code the block leaves unused: no effect, status done
   localparam logic [tpq_pkg::REQ_TYPE_W-1:0] REQ_SPARE = 2'd3;

   // one line of the directed table; reps > 1 inserts ids counting up from id
   typedef struct {
      logic [tpq_pkg::REQ_TYPE_W-1:0] kind;
      logic                           vip;
      int unsigned                    id;
      int unsigned                    reps;
      bit                             typed;
      tpq_pkg::rsp_type               view;
   } dir_row_type;

   // one request ready to send, with a hand-typed result where there is one
   typedef struct {
      tpq_pkg::req_type_type req;
      bit                    typed;
      tpq_pkg::rsp_type      view;
   } send_item_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   tpq_pkg::req_type_type req_data;
   logic                  rsp_valid;
   tpq_pkg::rsp_type      rsp_data;

   two_class_priority_queue_core #(
      .CLASS_DEPTH(CLASS_DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // predictor copy of the two class rings
   logic [tpq_pkg::ID_W-1:0] vip_slots    [CLASS_DEPTH];
   logic [tpq_pkg::ID_W-1:0] normal_slots [CLASS_DEPTH];
   logic [PTR_W-1:0]         vip_rd, vip_wr, normal_rd, normal_wr;
   int                       vip_held, normal_held;

   dir_row_type      dir_tbl [DIR_ROWS];
   send_item_type    send_q [$];
   tpq_pkg::rsp_type heads_due [$];   // predicted queue views, oldest first
   bit               mismatch_seen;
   int               cycle_count = 0;

   function automatic tpq_pkg::rsp_type mk_view(logic hv, logic hvip, int unsigned id,
                                                int unsigned vc, int unsigned tc,
                                                logic [tpq_pkg::STATUS_W-1:0] st);
      tpq_pkg::rsp_type v;
      v.head_valid     = hv;
      v.head_is_vip    = hvip;
      v.head_client_id = tpq_pkg::ID_W'(id);
      v.vip_count      = tpq_pkg::VIP_COUNT_W'(vc);
      v.total_count    = tpq_pkg::TOTAL_COUNT_W'(tc);
      v.status         = st;
      return v;
   endfunction

   // apply one request to the predictor and return the view the block should report
   function automatic tpq_pkg::rsp_type step_queue_view(tpq_pkg::req_type_type r);
      tpq_pkg::rsp_type v;
      v        = '0;
      v.status = tpq_pkg::STAT_DONE;
      case (r.req_type)
         tpq_pkg::REQ_INSERT: begin
            if (r.is_vip) begin
               if (vip_held >= CLASS_DEPTH) begin
                  v.status = tpq_pkg::STAT_FULL;
               end else begin
                  vip_slots[vip_wr] = r.client_id;
                  vip_wr            = vip_wr + PTR_W'(1);
                  vip_held++;
               end
            end else begin
               if (normal_held >= CLASS_DEPTH) begin
                  v.status = tpq_pkg::STAT_FULL;
               end else begin
                  normal_slots[normal_wr] = r.client_id;
                  normal_wr               = normal_wr + PTR_W'(1);
                  normal_held++;
               end
            end
         end
         tpq_pkg::REQ_REMOVE: begin
            // vip entries always leave first
            if (vip_held > 0) begin
               vip_rd = vip_rd + PTR_W'(1);
               vip_held--;
            end else if (normal_held > 0) begin
               normal_rd = normal_rd + PTR_W'(1);
               normal_held--;
            end else begin
               v.status = tpq_pkg::STAT_EMPTY_REM;
            end
         end
         tpq_pkg::REQ_CLEAR: begin
            vip_rd      = '0;
            vip_wr      = '0;
            normal_rd   = '0;
            normal_wr   = '0;
            vip_held    = 0;
            normal_held = 0;
         end
         default: ;
      endcase
      if (vip_held > 0) begin
         v.head_valid     = 1'b1;
         v.head_is_vip    = 1'b1;
         v.head_client_id = vip_slots[vip_rd];
      end else if (normal_held > 0) begin
         v.head_valid     = 1'b1;
         v.head_client_id = normal_slots[normal_rd];
      end
      v.vip_count   = tpq_pkg::VIP_COUNT_W'(vip_held);
      v.total_count = tpq_pkg::TOTAL_COUNT_W'(vip_held + normal_held);
      return v;
   endfunction

   function automatic int unsigned pick_id();
      int unsigned sel;
      sel = $urandom_range(0, 15);
      if (sel == 0) return 0;
      if (sel == 1) return MAX_ID;
      return $urandom_range(0, MAX_ID);
   endfunction

   task automatic report_field(string name, int unsigned due, int unsigned seen);
      if (due != seen) begin
         $error("%s mismatch: expected %0d, got %0d", name, due, seen);
         mismatch_seen = 1'b1;
      end
   endtask

   // directed table: extremes, every request code, full classes, last vip leaving
   initial begin
      dir_tbl[0]  = '{tpq_pkg::REQ_REMOVE, 1'b0, 0, 1, 1'b1,
                      mk_view(1'b0, 1'b0, 0, 0, 0, tpq_pkg::STAT_EMPTY_REM)};
      dir_tbl[1]  = '{tpq_pkg::REQ_CLEAR, 1'b1, MAX_ID, 1, 1'b1,
                      mk_view(1'b0, 1'b0, 0, 0, 0, tpq_pkg::STAT_DONE)};
      dir_tbl[2]  = '{tpq_pkg::REQ_INSERT, 1'b0, 0, 1, 1'b1,
                      mk_view(1'b1, 1'b0, 0, 0, 1, tpq_pkg::STAT_DONE)};
      dir_tbl[3]  = '{tpq_pkg::REQ_INSERT, 1'b1, MAX_ID, 1, 1'b1,
                      mk_view(1'b1, 1'b1, MAX_ID, 1, 2, tpq_pkg::STAT_DONE)};
      dir_tbl[4]  = '{tpq_pkg::REQ_INSERT, 1'b1, 1, 1, 1'b0, '0};
      dir_tbl[5]  = '{tpq_pkg::REQ_INSERT, 1'b0, MAX_ID, 1, 1'b0, '0};
      dir_tbl[6]  = '{tpq_pkg::REQ_REMOVE, 1'b1, MAX_ID, 1, 1'b0, '0};  // class and id ignored
      dir_tbl[7]  = '{tpq_pkg::REQ_REMOVE, 1'b0, 0, 1, 1'b0, '0};       // last vip leaves
      dir_tbl[8]  = '{tpq_pkg::REQ_INSERT, 1'b1, 7, 1, 1'b0, '0};       // vip back at head
      dir_tbl[9]  = '{REQ_SPARE, 1'b1, MAX_ID, 1, 1'b0, '0};
      dir_tbl[10] = '{tpq_pkg::REQ_REMOVE, 1'b0, 0, 1, 1'b0, '0};
      dir_tbl[11] = '{tpq_pkg::REQ_REMOVE, 1'b0, 0, 1, 1'b0, '0};
      dir_tbl[12] = '{tpq_pkg::REQ_REMOVE, 1'b0, 0, 1, 1'b0, '0};
      dir_tbl[13] = '{tpq_pkg::REQ_REMOVE, 1'b1, 5, 1, 1'b1,
                      mk_view(1'b0, 1'b0, 0, 0, 0, tpq_pkg::STAT_EMPTY_REM)};
      dir_tbl[14] = '{tpq_pkg::REQ_INSERT, 1'b1, 1000, CLASS_DEPTH, 1'b0, '0};
      dir_tbl[15] = '{tpq_pkg::REQ_INSERT, 1'b1, 5, 1, 1'b0, '0};       // vip class full
      dir_tbl[16] = '{tpq_pkg::REQ_INSERT, 1'b0, 2000, CLASS_DEPTH, 1'b0, '0};
      dir_tbl[17] = '{tpq_pkg::REQ_INSERT, 1'b0, 6, 1, 1'b0, '0};       // normal class full
      dir_tbl[18] = '{tpq_pkg::REQ_REMOVE, 1'b0, 0, 1, 1'b0, '0};
      dir_tbl[19] = '{tpq_pkg::REQ_INSERT, 1'b1, 9, 1, 1'b0, '0};       // one vip slot free again
      dir_tbl[20] = '{tpq_pkg::REQ_CLEAR, 1'b0, 0, 1, 1'b1,
                      mk_view(1'b0, 1'b0, 0, 0, 0, tpq_pkg::STAT_DONE)};
      dir_tbl[21] = '{tpq_pkg::REQ_INSERT, 1'b1, 3, 1, 1'b1,
                      mk_view(1'b1, 1'b1, 3, 1, 1, tpq_pkg::STAT_DONE)};
   end

   // give up on a hang
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: every strobed cycle is one transfer, compared with the oldest prediction
   always @(posedge clock) begin : watch_results
      tpq_pkg::rsp_type due;
      if (!reset && rsp_valid) begin
         if (heads_due.size() == 0) begin
            $error("result transfer with no request outstanding");
            mismatch_seen = 1'b1;
         end else begin
            due = heads_due.pop_front();
            report_field("head_valid", 32'(due.head_valid), 32'(rsp_data.head_valid));
            report_field("head_is_vip", 32'(due.head_is_vip), 32'(rsp_data.head_is_vip));
            report_field("head_client_id", 32'(due.head_client_id),
                         32'(rsp_data.head_client_id));
            report_field("vip_count", 32'(due.vip_count), 32'(rsp_data.vip_count));
            report_field("total_count", 32'(due.total_count), 32'(rsp_data.total_count));
            report_field("status", 32'(due.status), 32'(rsp_data.status));
         end
      end
   end

   // stimulus build, request side driving and end of run
   initial begin : run_requests
      send_item_type                  it;
      tpq_pkg::rsp_type               predicted;
      logic [tpq_pkg::REQ_TYPE_W-1:0] kind;
      bit                             filling;
      int                             phase_left;
      int                             counted;
      int                             sel;
      int                             idx;
      int                             burst_left;
      int                             gap_left;

      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;
      mismatch_seen = 1'b0;
      vip_slots     = '{default: '0};
      normal_slots  = '{default: '0};
      vip_rd        = '0;
      vip_wr        = '0;
      normal_rd     = '0;
      normal_wr     = '0;
      vip_held      = 0;
      normal_held   = 0;

      // expand the directed table; repeated rows count their ids up
      #1;
      foreach (dir_tbl[r]) begin
         for (int k = 0; k < dir_tbl[r].reps; k++) begin
            it.req.req_type  = dir_tbl[r].kind;
            it.req.is_vip    = dir_tbl[r].vip;
            it.req.client_id = tpq_pkg::ID_W'(dir_tbl[r].id + k);
            it.typed         = dir_tbl[r].typed && (dir_tbl[r].reps == 1);
            it.view          = dir_tbl[r].view;
            send_q.push_back(it);
         end
      end

      // random part: alternating fill and drain phases so both classes reach full
      // and empty often; clears and the unused code are sprinkled in as noise
      filling    = 1'b1;
      phase_left = $urandom_range(30, 90);
      counted    = 0;
      while (counted < RAND_ITEMS) begin
         if (phase_left == 0) begin
            filling    = !filling;
            phase_left = $urandom_range(30, 90);
         end
         phase_left--;
         sel = $urandom_range(0, 99);
         if (sel < 1)
            kind = tpq_pkg::REQ_CLEAR;
         else if (sel < 3)
            kind = REQ_SPARE;
         else if (sel < (filling ? 80 : 25))
            kind = tpq_pkg::REQ_INSERT;
         else
            kind = tpq_pkg::REQ_REMOVE;
         it.req.req_type  = kind;
         it.req.is_vip    = 1'($urandom_range(0, 1));
         it.req.client_id = tpq_pkg::ID_W'(pick_id());
         it.typed         = 1'b0;
         it.view          = '0;
         send_q.push_back(it);
         if (kind != REQ_SPARE) counted++;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // request side: bursts of random length separated by random gaps,
      // some bursts back to back with no gap at all
      idx        = 0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
      while (idx < send_q.size() || start) begin
         @(posedge clock);
         if (start && !busy) begin
            // transfer of the request on req_data at this edge
            predicted = step_queue_view(req_data);
            heads_due.push_back(send_q[idx].typed ? send_q[idx].view : predicted);
            idx++;
         end
         if (!start || !busy) begin
            if (idx >= send_q.size()) begin
               start <= 1'b0;
            end else if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else begin
               start    <= 1'b1;
               req_data <= send_q[idx].req;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end

      // let every outstanding result arrive, then a few quiet cycles
      while (heads_due.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (!mismatch_seen && heads_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[two_class_priority_queue_core.f]
rtl/core/tpq_pkg.sv
rtl/core/tpq_ring.sv
rtl/core/two_class_priority_queue_core.sv
sim/tb_two_class_priority_queue_core.sv
